>>> rtl/tpse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpse_pkg
// Shared constants, op codes and the transaction record that moves along
// the spline evaluation chain.
// ----------------------------------------------------------------------------
package tpse_pkg;

    // number of knots, one chain cell each
    localparam int NUM_KNOTS = 16;

    // accumulator width, wide enough for the full unsaturated sum
    localparam int ACC_W = 52;
    // result width (Q31.16)
    localparam int FIT_W = 48;
    // width for cell numbers, knot counts and table index compares
    localparam int CMP_W = 8;

    // reset value of the active knot count
    localparam logic [4:0] ACTIVE_KNOTS_RST = 5'd16;

    // op codes
    localparam logic [1:0] OP_EVAL = 2'd0;
    localparam logic [1:0] OP_COEF = 2'd1;
    localparam logic [1:0] OP_KNOT = 2'd2;

    // coefficients below the knot terms
    localparam int NUM_POLY = 3;

    // configuration register index
    localparam logic REG_ACTIVE_KNOTS = 1'b0;

    // one transaction as it travels down the chain
    typedef struct packed {
        logic                    valid;
        logic [1:0]              op;
        logic [4:0]              index;
        logic [31:0]             value;
        logic signed [15:0]      x;
        logic signed [ACC_W-1:0] acc;
    } item_t;

endpackage

>>> rtl/tpse_head.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpse_head
// Holds coefficients c0..c2 and starts each sum with c0 + c1*x + c2*x^2.
// Three stages; writes to c0..c2 take effect as they enter.
// ----------------------------------------------------------------------------
module tpse_head
    import tpse_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  shift_en,
    input  item_t item_in,
    output item_t item_out
);

    // coefficient storage
    logic signed [31:0] c0_reg, c1_reg, c2_reg;

    // stage 1
    item_t              h1_item_reg;
    logic signed [31:0] h1_c0_reg, h1_c1_reg, h1_c2_reg;

    // stage 2
    item_t              h2_item_reg;
    logic signed [31:0] h2_c0_reg, h2_c2_reg;
    logic [16:0]        h2_x2_reg, h2_x2_next;
    logic signed [33:0] h2_lin_reg, h2_lin_next;

    // stage 3
    item_t              h3_item_reg, h3_item_next;
    logic signed [35:0] h3_sq_reg, h3_sq_next;

    logic signed [31:0] x_sq;
    logic signed [47:0] lin_prod;
    logic signed [49:0] sq_prod;
    logic               coef_wr;

    assign coef_wr = item_in.valid && (item_in.op == OP_COEF);

    // coefficient writes as a transaction enters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c0_reg <= '0;
            c1_reg <= '0;
            c2_reg <= '0;
        end
        else if (shift_en && coef_wr)
        begin
            if (item_in.index == 5'd0)
                c0_reg <= item_in.value;
            if (item_in.index == 5'd1)
                c1_reg <= item_in.value;
            if (item_in.index == 5'd2)
                c2_reg <= item_in.value;
        end
    end

    // x squared and linear term
    assign x_sq        = h1_item_reg.x * h1_item_reg.x;
    assign h2_x2_next  = x_sq[30:14];
    assign lin_prod    = h1_c1_reg * h1_item_reg.x;
    assign h2_lin_next = lin_prod[47:14];

    // square term and partial sum
    assign sq_prod    = h2_c2_reg * $signed({1'b0, h2_x2_reg});
    assign h3_sq_next = sq_prod[49:14];

    always_comb
    begin
        h3_item_next     = h2_item_reg;
        h3_item_next.acc = {{(ACC_W-32){h2_c0_reg[31]}}, h2_c0_reg}
                         + {{(ACC_W-34){h2_lin_reg[33]}}, h2_lin_reg};
    end

    // pipeline registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h1_item_reg <= '0;
            h2_item_reg <= '0;
            h3_item_reg <= '0;
            h1_c0_reg   <= '0;
            h1_c1_reg   <= '0;
            h1_c2_reg   <= '0;
            h2_c0_reg   <= '0;
            h2_c2_reg   <= '0;
            h2_x2_reg   <= '0;
            h2_lin_reg  <= '0;
            h3_sq_reg   <= '0;
        end
        else if (shift_en)
        begin
            h1_item_reg <= item_in;
            h1_c0_reg   <= c0_reg;
            h1_c1_reg   <= c1_reg;
            h1_c2_reg   <= c2_reg;
            h2_item_reg <= h1_item_reg;
            h2_c0_reg   <= h1_c0_reg;
            h2_c2_reg   <= h1_c2_reg;
            h2_x2_reg   <= h2_x2_next;
            h2_lin_reg  <= h2_lin_next;
            h3_item_reg <= h3_item_next;
            h3_sq_reg   <= h3_sq_next;
        end
    end

    // close the polynomial part of the sum
    always_comb
    begin
        item_out     = h3_item_reg;
        item_out.acc = h3_item_reg.acc + {{(ACC_W-36){h3_sq_reg[35]}}, h3_sq_reg};
    end

endmodule

>>> rtl/tpse_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpse_cell
// One knot of the chain: holds its knot and coefficient and adds
// c * max(0, x - k)^3 to the passing sum while the cell is active. Four stages.
// ----------------------------------------------------------------------------
module tpse_cell
    import tpse_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             shift_en,
    input  logic [CMP_W-1:0] cell_idx,
    input  logic [CMP_W-1:0] knot_count,
    input  item_t            item_in,
    output item_t            item_out
);

    // knot and coefficient storage
    logic signed [15:0] knot_reg;
    logic signed [31:0] coef_reg;

    // stage 1
    item_t              r1_item_reg;
    logic signed [16:0] r1_d_reg, r1_d_next;
    logic signed [31:0] r1_coef_reg;
    logic               r1_on_reg;

    // stage 2
    item_t              r2_item_reg;
    logic [15:0]        r2_d_reg;
    logic [17:0]        r2_d2_reg;
    logic signed [31:0] r2_coef_reg;
    logic               r2_on_reg;

    // stage 3
    item_t              r3_item_reg;
    logic [19:0]        r3_d3_reg;
    logic signed [31:0] r3_coef_reg;
    logic               r3_on_reg;

    // stage 4
    item_t              r4_item_reg;
    logic signed [38:0] r4_term_reg, r4_term_next;

    logic [CMP_W-1:0]   wr_idx;
    logic               knot_hit, coef_hit, cell_active;
    logic [31:0]        d_sq;
    logic [33:0]        d_cube;
    logic signed [52:0] term_prod;

    assign wr_idx      = {{(CMP_W-5){1'b0}}, item_in.index};
    assign knot_hit    = item_in.valid && (item_in.op == OP_KNOT) && (wr_idx == cell_idx);
    assign coef_hit    = item_in.valid && (item_in.op == OP_COEF)
                      && (wr_idx == cell_idx + CMP_W'(NUM_POLY));
    assign cell_active = cell_idx < knot_count;

    // table writes as a transaction enters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            knot_reg <= '0;
            coef_reg <= '0;
        end
        else if (shift_en)
        begin
            if (knot_hit)
                knot_reg <= item_in.value[15:0];
            if (coef_hit)
                coef_reg <= item_in.value;
        end
    end

    // distance from knot
    assign r1_d_next = {item_in.x[15], item_in.x} - {knot_reg[15], knot_reg};

    // square, cube and coefficient product
    assign d_sq         = r1_d_reg[15:0] * r1_d_reg[15:0];
    assign d_cube       = r2_d2_reg * r2_d_reg;
    assign term_prod    = r3_coef_reg * $signed({1'b0, r3_d3_reg});
    assign r4_term_next = r3_on_reg ? term_prod[52:14] : '0;

    // pipeline registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r1_item_reg <= '0;
            r2_item_reg <= '0;
            r3_item_reg <= '0;
            r4_item_reg <= '0;
            r1_d_reg    <= '0;
            r1_coef_reg <= '0;
            r1_on_reg   <= 1'b0;
            r2_d_reg    <= '0;
            r2_d2_reg   <= '0;
            r2_coef_reg <= '0;
            r2_on_reg   <= 1'b0;
            r3_d3_reg   <= '0;
            r3_coef_reg <= '0;
            r3_on_reg   <= 1'b0;
            r4_term_reg <= '0;
        end
        else if (shift_en)
        begin
            r1_item_reg <= item_in;
            r1_d_reg    <= r1_d_next;
            r1_coef_reg <= coef_reg;
            r1_on_reg   <= cell_active && !r1_d_next[16] && (r1_d_next != '0);
            r2_item_reg <= r1_item_reg;
            r2_d_reg    <= r1_d_reg[15:0];
            r2_d2_reg   <= d_sq[31:14];
            r2_coef_reg <= r1_coef_reg;
            r2_on_reg   <= r1_on_reg;
            r3_item_reg <= r2_item_reg;
            r3_d3_reg   <= d_cube[33:14];
            r3_coef_reg <= r2_coef_reg;
            r3_on_reg   <= r2_on_reg;
            r4_item_reg <= r3_item_reg;
            r4_term_reg <= r4_term_next;
        end
    end

    // add this knot's term to the sum
    always_comb
    begin
        item_out     = r4_item_reg;
        item_out.acc = r4_item_reg.acc + {{(ACC_W-39){r4_term_reg[38]}}, r4_term_reg};
    end

endmodule

>>> rtl/tpse_tail.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpse_tail
// Output register: saturates the sum to Q31.16 and holds the result
// until it is taken. Write transactions end here with no result.
// ----------------------------------------------------------------------------
module tpse_tail
    import tpse_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    shift_en,
    input  item_t                   item_in,
    output logic                    out_valid,
    output logic signed [FIT_W-1:0] fit_value,
    output logic                    saturated
);

    logic                    out_valid_reg, out_valid_next;
    logic signed [FIT_W-1:0] fit_reg, fit_next;
    logic                    sat_reg, sat_next;
    logic [ACC_W-FIT_W:0]    top_bits;
    logic                    fits;

    // the sum fits when the result sign bit and all bits above it agree
    assign top_bits = item_in.acc[ACC_W-1:FIT_W-1];
    assign fits     = (top_bits == '0) || (top_bits == '1);

    // saturation
    always_comb
    begin
        out_valid_next = item_in.valid && (item_in.op == OP_EVAL);
        sat_next       = !fits;
        if (fits)
            fit_next = item_in.acc[FIT_W-1:0];
        else if (item_in.acc[ACC_W-1])
            fit_next = {1'b1, {(FIT_W-1){1'b0}}};
        else
            fit_next = {1'b0, {(FIT_W-1){1'b1}}};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            fit_reg       <= '0;
            sat_reg       <= 1'b0;
        end
        else if (shift_en)
        begin
            out_valid_reg <= out_valid_next;
            fit_reg       <= fit_next;
            sat_reg       <= sat_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign fit_value = fit_reg;
    assign saturated = sat_reg;

endmodule

>>> rtl/truncated_power_spline_eval_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// truncated_power_spline_eval_core
// Cubic spline evaluation in truncated power basis, fixed point.
// ----------------------------------------------------------------------------
// Every transaction (evaluate, coefficient write or knot write) runs in order
// through a 3-stage head that holds c0..c2, a chain of NUM_KNOTS identical
// 4-stage cells that each hold one knot and its coefficient, and an output
// register that holds each evaluate result until it is read. A new
// transaction is accepted every cycle while the output register is free or
// being read; the whole chain holds while a result waits. Writes act on the
// tables as they pass the owning stage, so they affect only evaluations
// accepted after them. Tables reset to zero through flops, with no clearing
// pass. active_knots sits at byte address 0 of the APB port and should be
// changed only while idle.
// ----------------------------------------------------------------------------
module truncated_power_spline_eval_core
    import tpse_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    // input channel
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [1:0]              op,
    input  logic [4:0]              index,
    input  logic signed [31:0]      value,
    input  logic signed [15:0]      x_pos,
    // output channel
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [FIT_W-1:0] fit_value,
    output logic                    saturated,
    // configuration port
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [2:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    logic [4:0]       active_knots_reg;
    logic [CMP_W-1:0] knot_count;
    logic             shift_en;
    item_t            head_in;
    item_t            chain [NUM_KNOTS+1];

    // configuration register
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            active_knots_reg <= ACTIVE_KNOTS_RST;
        else if (psel && penable && pwrite && (paddr[2] == REG_ACTIVE_KNOTS))
            active_knots_reg <= pwdata[4:0];
    end

    assign prdata = (paddr[2] == REG_ACTIVE_KNOTS) ? {27'd0, active_knots_reg} : 32'd0;

    // knot count limited to the chain length
    assign knot_count = ({{(CMP_W-5){1'b0}}, active_knots_reg} > CMP_W'(NUM_KNOTS))
                      ? CMP_W'(NUM_KNOTS) : {{(CMP_W-5){1'b0}}, active_knots_reg};

    // chain moves unless a result is waiting
    assign shift_en = !out_valid || out_ready;
    assign in_ready = shift_en;

    // incoming transaction
    always_comb
    begin
        head_in       = '0;
        head_in.valid = in_valid;
        head_in.op    = op;
        head_in.index = index;
        head_in.value = value;
        head_in.x     = x_pos;
    end

    tpse_head u_head (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (shift_en),
        .item_in  (head_in),
        .item_out (chain[0])
    );

    // knot cells
    for (genvar i = 0; i < NUM_KNOTS; i++)
    begin : g_cell
        tpse_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .shift_en   (shift_en),
            .cell_idx   (CMP_W'(i)),
            .knot_count (knot_count),
            .item_in    (chain[i]),
            .item_out   (chain[i+1])
        );
    end

    tpse_tail u_tail (
        .clk       (clk),
        .rst_n     (rst_n),
        .shift_en  (shift_en),
        .item_in   (chain[NUM_KNOTS]),
        .out_valid (out_valid),
        .fit_value (fit_value),
        .saturated (saturated)
    );

endmodule
